// ===== rtl/ascii_unsigned_integer_parser_unit_defines.svh =====
// Assertion macros shared by the parser RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef ASCII_UNSIGNED_INTEGER_PARSER_UNIT_DEFINES_SVH
`define ASCII_UNSIGNED_INTEGER_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define AUP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aup: property failed");
`define AUP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("aup: invariant violated");
`else
`define AUP_ASSERT(lbl, prop)
`define AUP_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/aup_pkg.sv =====
// Types, character constants and the digit decoder of the ASCII parser.
// No dependencies.
package aup_pkg;

  localparam int unsigned RadixBits  = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [5:0] MaxRadix = 6'd36;
  localparam logic [5:0] NoDigit  = 6'd63;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLoX   = 8'h78;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] UpBias  = ChUpA - 8'd10;
  localparam logic [7:0] LoBias  = ChLoA - 8'd10;

  typedef struct packed {
    logic [5:0] digit;
    logic       is_space;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       last;
    logic [5:0] radix;
  } class_t;

  typedef enum logic [7:0] {
    PH_START  = 8'b0000_0001,
    PH_SPACE  = 8'b0000_0010,
    PH_SIGN   = 8'b0000_0100,
    PH_ZERO   = 8'b0000_1000,
    PH_ZEROX  = 8'b0001_0000,
    PH_DIGITS = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_BAD    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic bad;
    logic seen;
    logic ovf;
    logic neg;
  } res_flags_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = c - UpBias;
    end else if (c >= ChLoA && c <= ChLoZ) begin
      d = c - LoBias;
    end else begin
      d = {2'b00, NoDigit};
    end
    return d[5:0];
  endfunction

endpackage

// ===== rtl/aup_front.sv =====
// Front end: accepts characters, classifies them and queues the classes.
// Depends on aup_pkg and the assertion macro header.
`include "ascii_unsigned_integer_parser_unit_defines.svh"
module aup_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     char_code,
  input  logic [5:0]     radix,
  input  logic           last,
  input  logic           push,
  output logic           full,
  output aup_pkg::class_t item,
  output logic           item_valid,
  input  logic           take
);

  localparam int unsigned PtrBits = (aup_pkg::QueueDepth > 1) ? $clog2(aup_pkg::QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(aup_pkg::QueueDepth + 1);
  localparam logic [PtrBits-1:0] LastSlot = PtrBits'(aup_pkg::QueueDepth - 1);
  localparam logic [CntBits-1:0] FullCnt  = CntBits'(aup_pkg::QueueDepth);

  aup_pkg::class_t slots [aup_pkg::QueueDepth];
  aup_pkg::class_t cls;
  logic [PtrBits-1:0] wr_ptr, rd_ptr;
  logic [CntBits-1:0] cnt;
  logic wr_en, rd_en;

  always_comb begin
    cls.digit    = aup_pkg::digit_of(char_code);
    cls.is_space = (char_code == aup_pkg::ChSpace) ||
                   (char_code >= aup_pkg::ChTab && char_code <= aup_pkg::ChCr);
    cls.is_minus = (char_code == aup_pkg::ChMinus);
    cls.is_plus  = (char_code == aup_pkg::ChPlus);
    cls.is_zero  = (char_code == aup_pkg::ChZero);
    cls.is_x     = (char_code == aup_pkg::ChUpX) || (char_code == aup_pkg::ChLoX);
    cls.last     = last;
    cls.radix    = radix;
  end

  assign full       = (cnt == FullCnt);
  assign item_valid = (cnt != '0);
  assign item       = slots[rd_ptr];
  assign wr_en      = push && !full;
  assign rd_en      = take && item_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `AUP_NEVER(a_front_overrun, cnt > FullCnt)
  `AUP_NEVER(a_front_underrun, take && cnt == '0)

endmodule

// ===== rtl/aup_back.sv =====
// Back end: runs the parse state machine, one multiply-add per character,
// and holds finished results in a small output queue. Depends on aup_pkg.
`include "ascii_unsigned_integer_parser_unit_defines.svh"
module aup_back #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  aup_pkg::class_t       item,
  input  logic                  item_valid,
  output logic                  take,
  output logic [VALUE_BITS-1:0] value,
  output logic [COUNT_BITS-1:0] consumed,
  output logic                  overflowed,
  output logic                  bad_radix,
  output logic                  empty,
  input  logic                  pop
);

  localparam int unsigned ProdBits = VALUE_BITS + aup_pkg::RadixBits;
  localparam int unsigned PtrBits  = (aup_pkg::QueueDepth > 1) ? $clog2(aup_pkg::QueueDepth) : 1;
  localparam int unsigned CntBits  = $clog2(aup_pkg::QueueDepth + 1);
  localparam logic [PtrBits-1:0]    LastSlot = PtrBits'(aup_pkg::QueueDepth - 1);
  localparam logic [CntBits-1:0]    FullCnt  = CntBits'(aup_pkg::QueueDepth);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  aup_pkg::phase_t       phase, ph_cur, ph_nxt;
  logic                  negative, neg_v;
  logic [5:0]            active_radix, rad;
  logic [VALUE_BITS-1:0] accumulator, acc_v;
  logic                  seen, seen_v, ovf, ovf_v;
  logic [COUNT_BITS-1:0] position, end_position, pos, pos_inc, endp;
  logic                  do_take;
  logic [ProdBits-1:0]   prod;

  logic [VALUE_BITS-1:0] o_acc   [aup_pkg::QueueDepth];
  logic [COUNT_BITS-1:0] o_endp  [aup_pkg::QueueDepth];
  aup_pkg::res_flags_t   o_flags [aup_pkg::QueueDepth];
  aup_pkg::res_flags_t   head;
  logic [PtrBits-1:0]    o_wr, o_rd;
  logic [CntBits-1:0]    o_cnt;
  logic                  o_push, o_pop;

  assign take   = item_valid && (o_cnt != FullCnt);
  assign o_push = take && item.last;
  assign o_pop  = pop && !empty;

  always_comb begin
    ph_cur  = phase;
    neg_v   = negative;
    rad     = active_radix;
    acc_v   = accumulator;
    seen_v  = seen;
    ovf_v   = ovf;
    pos     = position;
    endp    = end_position;
    do_take = 1'b0;
    prod    = '0;
    if (phase == aup_pkg::PH_START) begin
      neg_v  = 1'b0;
      acc_v  = '0;
      seen_v = 1'b0;
      ovf_v  = 1'b0;
      endp   = '0;
      pos    = '0;
      if (item.radix == 6'd1 || item.radix > aup_pkg::MaxRadix) begin
        ph_cur = aup_pkg::PH_BAD;
      end else begin
        rad    = item.radix;
        ph_cur = aup_pkg::PH_SPACE;
      end
    end
    pos_inc = (pos == CountMax) ? pos : pos + 1'b1;
    ph_nxt  = ph_cur;

    unique case (ph_cur)
      aup_pkg::PH_SPACE, aup_pkg::PH_SIGN: begin
        if (ph_cur == aup_pkg::PH_SPACE && item.is_space) begin
          ph_nxt = ph_cur;
        end else if (ph_cur == aup_pkg::PH_SPACE && item.is_minus) begin
          neg_v  = 1'b1;
          ph_nxt = aup_pkg::PH_SIGN;
        end else if (ph_cur == aup_pkg::PH_SPACE && item.is_plus) begin
          ph_nxt = aup_pkg::PH_SIGN;
        end else if ((rad == 6'd0 || rad == 6'd16) && item.is_zero) begin
          endp   = pos_inc;
          ph_nxt = aup_pkg::PH_ZERO;
        end else begin
          if (rad == 6'd0) rad = 6'd10;
          do_take = 1'b1;
        end
      end
      aup_pkg::PH_ZERO: begin
        if (item.is_x) begin
          ph_nxt = aup_pkg::PH_ZEROX;
        end else begin
          if (rad == 6'd0) rad = 6'd8;
          acc_v   = '0;
          seen_v  = 1'b1;
          do_take = 1'b1;
        end
      end
      aup_pkg::PH_ZEROX: begin
        if (item.digit < 6'd16) begin
          rad     = 6'd16;
          do_take = 1'b1;
        end else begin
          if (rad == 6'd0) rad = 6'd8;
          acc_v  = '0;
          seen_v = 1'b1;
          ph_nxt = aup_pkg::PH_DONE;
        end
      end
      aup_pkg::PH_DIGITS: do_take = 1'b1;
      default:            ph_nxt  = ph_cur;
    endcase

    if (do_take) begin
      if (item.digit >= rad || rad < 6'd2) begin
        ph_nxt = aup_pkg::PH_DONE;
      end else begin
        prod = ProdBits'(acc_v) * ProdBits'(rad) + ProdBits'(item.digit);
        if (ovf_v || (|prod[ProdBits-1:VALUE_BITS])) begin
          ovf_v = 1'b1;
        end else begin
          seen_v = 1'b1;
          acc_v  = prod[VALUE_BITS-1:0];
        end
        endp   = pos_inc;
        ph_nxt = aup_pkg::PH_DIGITS;
      end
    end

    if (item.last && (ph_nxt == aup_pkg::PH_ZERO || ph_nxt == aup_pkg::PH_ZEROX)) begin
      acc_v  = '0;
      seen_v = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= aup_pkg::PH_START;
      negative     <= 1'b0;
      active_radix <= '0;
      accumulator  <= '0;
      seen         <= 1'b0;
      ovf          <= 1'b0;
      position     <= '0;
      end_position <= '0;
    end else if (take) begin
      if (item.last) begin
        phase        <= aup_pkg::PH_START;
        negative     <= 1'b0;
        active_radix <= '0;
        accumulator  <= '0;
        seen         <= 1'b0;
        ovf          <= 1'b0;
        position     <= '0;
        end_position <= '0;
      end else begin
        phase        <= ph_nxt;
        negative     <= neg_v;
        active_radix <= rad;
        accumulator  <= acc_v;
        seen         <= seen_v;
        ovf          <= ovf_v;
        position     <= pos_inc;
        end_position <= endp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      o_acc[o_wr]   <= acc_v;
      o_endp[o_wr]  <= endp;
      o_flags[o_wr] <= '{bad: (ph_nxt == aup_pkg::PH_BAD), seen: seen_v,
                         ovf: ovf_v, neg: neg_v};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr  <= '0;
      o_rd  <= '0;
      o_cnt <= '0;
    end else begin
      if (o_push) begin
        o_wr <= (o_wr == LastSlot) ? '0 : o_wr + 1'b1;
      end
      if (o_pop) begin
        o_rd <= (o_rd == LastSlot) ? '0 : o_rd + 1'b1;
      end
      case ({o_push, o_pop})
        2'b10:   o_cnt <= o_cnt + 1'b1;
        2'b01:   o_cnt <= o_cnt - 1'b1;
        default: o_cnt <= o_cnt;
      endcase
    end
  end

  assign empty = (o_cnt == '0);
  assign head  = o_flags[o_rd];

  always_comb begin
    value      = '0;
    consumed   = '0;
    overflowed = 1'b0;
    bad_radix  = 1'b0;
    if (head.bad) begin
      bad_radix = 1'b1;
    end else if (head.ovf) begin
      value      = '1;
      consumed   = o_endp[o_rd];
      overflowed = 1'b1;
    end else if (head.seen) begin
      value    = head.neg ? ('0 - o_acc[o_rd]) : o_acc[o_rd];
      consumed = o_endp[o_rd];
    end
  end

  `AUP_NEVER(a_out_overrun, o_cnt > FullCnt)
  `AUP_ASSERT(a_restart_after_last, take && item.last |=> phase == aup_pkg::PH_START)
  `AUP_ASSERT(a_bad_result_clean, !empty && bad_radix |-> value == '0 && consumed == '0)
  `AUP_ASSERT(a_ovf_all_ones, !empty && overflowed |-> (&value) && !bad_radix)

endmodule

// ===== rtl/ascii_unsigned_integer_parser_unit.sv =====
// ASCII unsigned integer parser (strtoul rules), one character per transfer.
// Channels: input queue side push/full carries char_code, radix and last;
// result queue side empty/pop carries value, consumed, overflowed, bad_radix.
// radix is sampled on the first character of each string; 0 selects auto
// base, 1 or above 36 reports bad_radix with value 0.
// One result is produced per string, for the character marked last.
// A result is visible (empty low) once the back end has taken its last
// character. Throughput: one character per cycle while the result queue has
// room, set by the back end's single multiply-add and overflow check.
// The front end classifies characters into a two-entry queue; the back end
// holds up to two results, so input keeps flowing while a result waits.
// When pop is held low and both result slots are full, the back end halts
// and full rises once the character queue fills.
// Reset (rst, synchronous) empties both queues and starts a new string.
// Depends on aup_pkg, aup_front and aup_back.
module ascii_unsigned_integer_parser_unit #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            char_code,
  input  logic [5:0]            radix,
  input  logic                  last,
  input  logic                  push,
  output logic                  full,
  output logic [VALUE_BITS-1:0] value,
  output logic [COUNT_BITS-1:0] consumed,
  output logic                  overflowed,
  output logic                  bad_radix,
  output logic                  empty,
  input  logic                  pop
);

  aup_pkg::class_t item;
  logic            item_valid;
  logic            take;

  aup_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .radix      (radix),
    .last       (last),
    .push       (push),
    .full       (full),
    .item       (item),
    .item_valid (item_valid),
    .take       (take)
  );

  aup_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .take       (take),
    .value      (value),
    .consumed   (consumed),
    .overflowed (overflowed),
    .bad_radix  (bad_radix),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
